FILE: design/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Fixed field widths of the ports.
  localparam int REQ_W   = 1;
  localparam int ENT_W   = 10;
  localparam int FIELD_W = 32;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 11;

  // Width that holds a clamped table size, and signed search bounds.
  localparam int DEPTH_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int N_W        = (DEPTH_BITS > CFG_W) ? DEPTH_BITS : CFG_W;
  localparam int BND_W      = N_W + 1;

  // Width used to range-check a write address against the depth.
  localparam int ENT_CMP_W = ((ENT_W > DEPTH_BITS) ? ENT_W : DEPTH_BITS) + 1;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PROBE
  } state_e;

  typedef struct packed {
    op_e                           op;
    logic [IDX_W-1:0]              addr;
    logic signed [VALUE_WIDTH-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qent_t;

endpackage

`default_nettype wire

FILE: design/stbs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stbs_req_if;
  logic                                valid;
  logic                                ready;
  logic [stbs_pkg::REQ_W-1:0]          req_type;
  logic [stbs_pkg::ENT_W-1:0]          entry_index;
  logic signed [stbs_pkg::FIELD_W-1:0] write_value;
  logic signed [stbs_pkg::FIELD_W-1:0] search_key;

  modport source (output valid, req_type, entry_index, write_value, search_key,
                  input ready);
  modport sink (input valid, req_type, entry_index, write_value, search_key,
                output ready);
endinterface

interface stbs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [stbs_pkg::POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

interface stbs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [stbs_pkg::CFG_W-1:0] table_size;

  modport source (output valid, table_size, input ready);
  modport sink (input valid, table_size, output ready);
endinterface

`default_nettype wire

FILE: design/stbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/stbs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_front (
  stbs_req_if.sink              req_i,
  input  wire logic             full_i,
  output stbs_pkg::qent_t       push_o
);

  logic accept;
  logic write_ok;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && req_i.ready;

  // Writes beyond the table depth are dropped here and never reach the back.
  assign write_ok = stbs_pkg::ENT_CMP_W'(req_i.entry_index)
                    < stbs_pkg::ENT_CMP_W'(stbs_pkg::TABLE_DEPTH);

  always_comb begin
    push_o.cmd.op   = stbs_pkg::op_e'(req_i.req_type);
    push_o.cmd.addr = stbs_pkg::IDX_W'(req_i.entry_index);
    if (push_o.cmd.op == stbs_pkg::OP_LOOKUP) begin
      push_o.cmd.data = stbs_pkg::VALUE_WIDTH'(req_i.search_key);
      push_o.valid    = accept;
    end else begin
      push_o.cmd.data = stbs_pkg::VALUE_WIDTH'(req_i.write_value);
      push_o.valid    = accept && write_ok;
    end
  end

endmodule

`default_nettype wire

FILE: design/stbs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire stbs_pkg::qent_t push_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output stbs_pkg::qent_t      head_o
);

  stbs_pkg::cmd_t                 mem_q [stbs_pkg::QUEUE_DEPTH];
  logic [stbs_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [stbs_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [stbs_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o       = (cnt_q == stbs_pkg::QCNT_W'(stbs_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == stbs_pkg::QPTR_W'(stbs_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

FILE: design/stbs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  stbs_cfg_if.sink             cfg_i,
  stbs_rsp_if.source           rsp_o,
  input  wire stbs_pkg::qent_t head_i,
  output logic                 pop_o
);

  localparam logic signed [stbs_pkg::BND_W-1:0] ONE_B = 1;

  stbs_pkg::state_e                         state_q, state_d;
  logic [stbs_pkg::CFG_W-1:0]               table_size_q;
  logic signed [stbs_pkg::BND_W-1:0]        lo_q, lo_d;
  logic signed [stbs_pkg::BND_W-1:0]        hi_q, hi_d;
  logic [stbs_pkg::IDX_W-1:0]               mid_q, mid_d;
  logic signed [stbs_pkg::VALUE_WIDTH-1:0]  key_q, key_d;
  logic                                     rsp_valid_q, rsp_valid_d;
  logic                                     found_q, found_d;
  logic [stbs_pkg::POS_W-1:0]               pos_q, pos_d;

  logic [stbs_pkg::N_W-1:0]                 ts_ext;
  logic [stbs_pkg::N_W-1:0]                 n_eff;
  logic signed [stbs_pkg::BND_W-1:0]        hi_init;
  logic signed [stbs_pkg::BND_W-1:0]        mid_s;
  logic signed [stbs_pkg::BND_W-1:0]        hi_dn;
  logic signed [stbs_pkg::BND_W-1:0]        lo_up;
  logic [stbs_pkg::BND_W:0]                 sum_lo;
  logic [stbs_pkg::BND_W:0]                 sum_hi;
  logic signed [stbs_pkg::VALUE_WIDTH-1:0]  entry;

  logic                                     we;
  logic                                     re;
  logic [stbs_pkg::IDX_W-1:0]               raddr;
  logic [stbs_pkg::VALUE_WIDTH-1:0]         rdata;

  stbs_ram #(
    .WIDTH (stbs_pkg::VALUE_WIDTH),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (head_i.cmd.addr),
    .wdata_i (head_i.cmd.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_i.ready    = 1'b1;
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.found    = found_q;
  assign rsp_o.position = pos_q;

  // A size above the depth searches the whole table.
  assign ts_ext  = stbs_pkg::N_W'(table_size_q);
  assign n_eff   = (ts_ext > stbs_pkg::N_W'(stbs_pkg::TABLE_DEPTH))
                   ? stbs_pkg::N_W'(stbs_pkg::TABLE_DEPTH) : ts_ext;
  assign hi_init = $signed(stbs_pkg::BND_W'(n_eff)) - ONE_B;

  // Both candidate midpoints of the next probe are formed in parallel, so
  // the compare only selects one and the next read issues in the same cycle.
  assign mid_s  = $signed(stbs_pkg::BND_W'(mid_q));
  assign hi_dn  = mid_s - ONE_B;
  assign lo_up  = mid_s + ONE_B;
  assign sum_lo = (stbs_pkg::BND_W + 1)'(lo_q) + (stbs_pkg::BND_W + 1)'(hi_dn);
  assign sum_hi = (stbs_pkg::BND_W + 1)'(lo_up) + (stbs_pkg::BND_W + 1)'(hi_q);
  assign entry  = $signed(rdata);

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    rsp_valid_d = rsp_valid_q;
    found_d     = found_q;
    pos_d       = pos_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = mid_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          if (head_i.cmd.op == stbs_pkg::OP_WRITE) begin
            pop_o = 1'b1;
            we    = 1'b1;
          end else if (!rsp_valid_q) begin
            pop_o = 1'b1;
            key_d = head_i.cmd.data;
            if (n_eff == '0) begin
              rsp_valid_d = 1'b1;
              found_d     = 1'b0;
              pos_d       = '0;
            end else begin
              lo_d    = '0;
              hi_d    = hi_init;
              mid_d   = hi_init[stbs_pkg::IDX_W:1];
              re      = 1'b1;
              raddr   = hi_init[stbs_pkg::IDX_W:1];
              state_d = stbs_pkg::ST_PROBE;
            end
          end
        end
      end

      stbs_pkg::ST_PROBE: begin
        if (key_q == entry) begin
          rsp_valid_d = 1'b1;
          found_d     = 1'b1;
          pos_d       = stbs_pkg::POS_W'(mid_q);
          state_d     = stbs_pkg::ST_IDLE;
        end else if (key_q < entry) begin
          hi_d = hi_dn;
          if (lo_q > hi_dn) begin
            rsp_valid_d = 1'b1;
            found_d     = 1'b0;
            pos_d       = '0;
            state_d     = stbs_pkg::ST_IDLE;
          end else begin
            mid_d = sum_lo[stbs_pkg::IDX_W:1];
            re    = 1'b1;
            raddr = sum_lo[stbs_pkg::IDX_W:1];
          end
        end else begin
          lo_d = lo_up;
          if (lo_up > hi_q) begin
            rsp_valid_d = 1'b1;
            found_d     = 1'b0;
            pos_d       = '0;
            state_d     = stbs_pkg::ST_IDLE;
          end else begin
            mid_d = sum_hi[stbs_pkg::IDX_W:1];
            re    = 1'b1;
            raddr = sum_hi[stbs_pkg::IDX_W:1];
          end
        end
      end

      default: begin
        state_d = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= stbs_pkg::ST_IDLE;
      table_size_q <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        table_size_q <= cfg_i.table_size;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    key_q   <= key_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

endmodule

`default_nettype wire

FILE: design/sorted_table_binary_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary search over a table of signed entries that software fills one entry
// at a time and keeps in ascending order. An item either writes one entry
// (no result) or looks up a key among the first table_size entries and
// returns one result with a found flag and the matching position (position
// is 0 when the key is absent). Items enter a two-deep command queue, so the
// request side keeps accepting until the queue is full while a result waits
// on the response side. The search engine reads the table through one
// registered memory read port, one probe per cycle: a lookup issues its first
// read from the idle state, then each probe compares the returned entry and
// issues the next read or ends the search; a write is done in the idle state.
// An item that finds the queue empty reaches its head in the cycle after it
// is accepted. A lookup does not start while the previous result has not
// been taken. Entries that were never written read back undefined values,
// and the user must write table_size only while the block is idle; the
// block itself does not enforce this.
module sorted_table_binary_search (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stbs_req_if.sink   req_i,
  stbs_rsp_if.source rsp_o,
  stbs_cfg_if.sink   cfg_i
);

  stbs_pkg::qent_t push;
  stbs_pkg::qent_t head;
  logic            full;
  logic            pop;

  stbs_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push)
  );

  stbs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  stbs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .rsp_o  (rsp_o),
    .head_i (head),
    .pop_o  (pop)
  );

endmodule

`default_nettype wire

FILE: tb/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  // Enough cycles for a queued write or a full-depth lookup to leave the block.
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_ITEMS   = 200;

  localparam logic signed [FIELD_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam longint VAL_MAX = 64'sd2147483647;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  class search_scoreboard;
    logic signed [VALUE_WIDTH-1:0] entries [TABLE_DEPTH];
    logic [CFG_W-1:0]              table_size;
    answer_t                       expected_answers [$];
    int mismatches, lookups, hits, writes;

    function new();
      table_size = '0;
      mismatches = 0;
      lookups    = 0;
      hits       = 0;
      writes     = 0;
    endfunction

    function void set_table_size(logic [CFG_W-1:0] n);
      table_size = n;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    function int searched_entries();
      return (table_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
    endfunction

    // Midpoint walk over the entries in use; the first probe that matches wins.
    function answer_t search_for(logic signed [VALUE_WIDTH-1:0] key);
      answer_t ans;
      int lo, hi, mid;
      ans = '0;
      lo  = 0;
      hi  = searched_entries() - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key < entries[IDX_W'(mid)]) begin
          hi = mid - 1;
        end else if (key == entries[IDX_W'(mid)]) begin
          ans.found    = 1'b1;
          ans.position = POS_W'(mid);
          return ans;
        end else begin
          lo = mid + 1;
        end
      end
      return ans;
    endfunction

    function void note_request(op_e op, logic [ENT_W-1:0] idx,
                               logic signed [FIELD_W-1:0] wval,
                               logic signed [FIELD_W-1:0] key);
      answer_t ans;
      if (op == OP_WRITE) begin
        if (int'(idx) < TABLE_DEPTH) entries[idx] = wval;
        writes++;
      end else begin
        ans = search_for(key);
        expected_answers.push_back(ans);
        lookups++;
        if (ans.found) hits++;
      end
    endfunction

    function void check_response(logic found, logic [POS_W-1:0] position);
      answer_t exp_ans;
      if (expected_answers.size() == 0) begin
        $error("result with no lookup outstanding: found=%0b position=%0d", found, position);
        mismatches++;
        return;
      end
      exp_ans = expected_answers.pop_front();
      if (found !== exp_ans.found) begin
        $error("found: expected %0b, actual %0b", exp_ans.found, found);
        mismatches++;
      end
      if (position !== exp_ans.position) begin
        $error("position: expected %0d, actual %0d", exp_ans.position, position);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  stbs_req_if req_if ();
  stbs_rsp_if rsp_if ();
  stbs_cfg_if cfg_if ();

  sorted_table_binary_search uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  search_scoreboard sb;
  logic signed [FIELD_W-1:0] fill_vals [TABLE_DEPTH];
  int burst_left;
  int items_sent;
  int size_settings;
  int hold_count;
  bit hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input op_e op, input logic [ENT_W-1:0] idx,
                           input logic signed [FIELD_W-1:0] wval,
                           input logic signed [FIELD_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= op;
    req_if.entry_index <= idx;
    req_if.write_value <= wval;
    req_if.search_key  <= key;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(op, idx, wval, key);
    items_sent++;
  endtask

  task automatic send_write(input int idx, input logic signed [FIELD_W-1:0] wval);
    send_item(OP_WRITE, ENT_W'(idx), wval, $urandom);
  endtask

  task automatic send_lookup(input logic signed [FIELD_W-1:0] key);
    send_item(OP_LOOKUP, ENT_W'($urandom), $urandom, key);
  endtask

  // Lowers valid, waits for every outstanding result and lets queued writes drain.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] n);
    wait_idle();
    cfg_if.valid      <= 1'b1;
    cfg_if.table_size <= n;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.set_table_size(n);
    size_settings++;
  endtask

  // Mostly keys present in the searched range, then neighbors, extremes and noise.
  function automatic logic signed [FIELD_W-1:0] pick_key();
    int n_eff, k;
    logic signed [FIELD_W-1:0] v;
    n_eff = sb.searched_entries();
    k = $urandom_range(0, 19);
    if (n_eff == 0 || k < 3) return $urandom;
    v = sb.entries[IDX_W'($urandom_range(0, n_eff - 1))];
    if (k < 13) return v;
    if (k < 16) return v + 1;
    if (k < 18) return v - 1;
    return (k == 18) ? KEY_MIN : KEY_MAX;
  endfunction

  task automatic fill_table();
    longint v;
    int i;
    v = VAL_MIN;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) v = VAL_MAX;
      fill_vals[IDX_W'(i)] = v[FIELD_W-1:0];
      send_write(i, v[FIELD_W-1:0]);
      if ($urandom_range(0, 7) != 0) v = v + $urandom_range(0, 32'h7F_FFFF);
      if (v > VAL_MAX) v = VAL_MAX;
    end
  endtask

  task automatic run_directed();
    int i;
    // Empty table straight out of reset: no entry is ever read.
    send_lookup(KEY_MIN);
    send_lookup(32'sd0);
    fill_table();
    write_table_size(CFG_W'(TABLE_DEPTH));
    send_lookup(KEY_MIN);
    send_lookup(KEY_MAX);
    send_lookup(fill_vals[TABLE_DEPTH/2 - 1]);
    send_lookup(fill_vals[300] + 1);
    send_lookup(-32'sd1);
    // A size above the depth searches the whole table.
    write_table_size('1);
    send_lookup(KEY_MAX);
    send_lookup(fill_vals[1000]);
    write_table_size(1);
    send_lookup(fill_vals[0]);
    send_lookup(KEY_MAX);
    // Run of duplicates, then one entry out of order.
    for (i = 0; i < 5; i++) send_write(i, 32'sd7);
    write_table_size(5);
    send_lookup(32'sd7);
    send_write(2, 32'sd100);
    send_lookup(32'sd7);
    send_lookup(32'sd100);
  endtask

  task automatic search_whole_table(input logic [CFG_W-1:0] size_val, input int n_lookups,
                                    input bit with_pressure);
    int i;
    write_table_size(size_val);
    for (i = 0; i < n_lookups; i++) begin
      if (with_pressure && i == 20) hold_request = 1'b1;
      if (with_pressure && i == n_lookups / 2) wait_idle();
      send_lookup(pick_key());
    end
  endtask

  // Rewrites the searched prefix as a fresh ascending run with some lookups in between, then searches it.
  task automatic rewrite_and_search_prefix();
    int r, n, i, n_lookups;
    bit narrow;
    longint v, step_max;
    r = $urandom_range(0, 9);
    n = (r < 7) ? $urandom_range(1, 16) : ((r < 9) ? $urandom_range(17, 128)
                                                   : $urandom_range(129, 300));
    write_table_size(CFG_W'(n));
    narrow   = ($urandom_range(0, 2) == 0);
    step_max = narrow ? 64'sd2 : 64'sd4294967296 / (n + 1);
    if (narrow) v = longint'($signed($urandom));
    else v = VAL_MIN + $urandom_range(0, step_max[31:0]);
    for (i = 0; i < n; i++) begin
      if (v > VAL_MAX) v = VAL_MAX;
      send_write(i, v[FIELD_W-1:0]);
      v = v + $urandom_range(0, step_max[31:0]);
      if ($urandom_range(0, 7) == 0) send_lookup(pick_key());
    end
    if ($urandom_range(0, 9) == 0) send_write($urandom_range(0, n - 1), $urandom);
    if ($urandom_range(0, 9) == 0) send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
    n_lookups = $urandom_range(8, 30);
    for (i = 0; i < n_lookups; i++) send_lookup(pick_key());
  endtask

  task automatic run_random();
    int i, start;
    start = items_sent;
    // Put back the entries the directed part disturbed so the table is sorted again.
    for (i = 0; i < 5; i++) send_write(i, fill_vals[IDX_W'(i)]);
    search_whole_table(CFG_W'(TABLE_DEPTH), 60, 1'b1);
    search_whole_table(CFG_W'(TABLE_DEPTH + $urandom_range(1, 1023)), 20, 1'b0);
    search_whole_table(CFG_W'($urandom_range(129, 1023)), 20, 1'b0);
    while (items_sent - start < RANDOM_ITEMS - 40) rewrite_and_search_prefix();
    search_whole_table(0, 10, 1'b0);
    search_whole_table('1, 30, 1'b0);
  endtask

  // Response side: checks each result and stalls on its own pattern.
  initial begin
    int stall_left, pattern_left;
    logic [15:0] pattern;
    stall_left   = 0;
    pattern_left = 0;
    pattern      = '1;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        sb.check_response(rsp_if.found, rsp_if.position);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
        hold_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: pattern = '1;
            1: pattern = 16'($urandom);
            2: pattern = 16'h1111;
            default: pattern = 16'($urandom | $urandom);
          endcase
        end
        pattern_left--;
        rsp_if.ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("[sorted_table_binary_search] ERROR");
    $finish;
  end

  initial begin
    sb            = new();
    burst_left    = 0;
    items_sent    = 0;
    size_settings = 0;
    hold_count    = 0;
    hold_request  = 1'b0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= OP_WRITE;
    req_if.entry_index <= '0;
    req_if.write_value <= '0;
    req_if.search_key  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.table_size  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    wait_idle();
    $display("Ran %0d lookups (%0d hits, %0d misses) and %0d entry writes",
             sb.lookups, sb.hits, sb.lookups - sb.hits, sb.writes);
    $display("across %0d table_size settings from 0 to 2047, with %0d long response stall(s).",
             size_settings, hold_count);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[sorted_table_binary_search] OK");
    end else begin
      $display("[sorted_table_binary_search] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/stbs_pkg.sv
design/stbs_if.sv
design/stbs_ram.sv
design/stbs_front.sv
design/stbs_fifo.sv
design/stbs_back.sv
design/sorted_table_binary_search.sv
tb/sorted_table_binary_search_tb.sv
